/* design/twg_pkg.sv */
package twg_pkg;

    // Register map of the configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_RUNS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_KP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_KI  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_KD  = 3'd5;

    // Reset values of the registers
    localparam logic [30:0]        RST_TOLERANCE   = 31'd13107;
    localparam logic [15:0]        RST_WARMUP_RUNS = 16'd100;
    localparam logic [15:0]        RST_CYCLE_LIMIT = 16'd2000;
    localparam logic signed [31:0] RST_KP          = 32'sd13107;
    localparam logic signed [31:0] RST_KI          = 32'sd26;
    localparam logic signed [31:0] RST_KD          = 32'sd196608;
    localparam logic signed [31:0] RST_STEP_P      = RST_KP / 10;
    localparam logic signed [31:0] RST_STEP_I      = RST_KI / 10;
    localparam logic signed [31:0] RST_STEP_D      = RST_KD / 10;

    // Gain slots always present on the result port
    localparam int GAIN_SLOTS = 3;

    // Step scaling factors (numerators over a divisor of ten)
    localparam logic [3:0]  SCALE_UP   = 4'd11;
    localparam logic [3:0]  SCALE_DOWN = 4'd9;
    localparam logic [15:0] TEN        = 16'd10;

    typedef struct packed {
        logic signed [15:0] cross_track_error;
    } t_sample;

    typedef struct packed {
        logic signed [31:0] gain_p;
        logic signed [31:0] gain_i;
        logic signed [31:0] gain_d;
        logic [47:0]        average_error;
    } t_result;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Clamp a wide signed value to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [35:0] lim_hi;
        logic signed [35:0] lim_lo;
        lim_hi = 36'sd2147483647;
        lim_lo = -36'sd2147483648;
        if (v > lim_hi) begin
            return 32'sh7FFFFFFF;
        end else if (v < lim_lo) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

/* design/twg_stream_if.sv */
interface twg_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/twg_sdiv.sv */
// Restoring divider, one quotient bit per cycle
module twg_sdiv import twg_pkg::*; #(
    parameter int DW = 48,
    parameter int VW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output t_div_stat     o_stat,
    output logic [DW-1:0] o_quotient
);
    localparam int CW = $clog2(DW);

    logic [DW-1:0] r_q;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [VW:0]   n_shift;
    logic          n_ge;
    logic [VW:0]   n_diff;

    // Trial subtract of the divisor from the shifted remainder
    always_comb begin
        n_shift = {r_rem, r_q[DW-1]};
        n_ge    = n_shift >= {1'b0, r_div};
        n_diff  = n_shift - {1'b0, r_div};
    end

    // Control: count DW steps after a start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift the quotient in as the dividend shifts out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DW-2:0], n_ge};
            r_rem <= n_ge ? n_diff[VW-1:0] : n_shift[VW-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_q;

`ifndef ASSERT_OFF
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done longer than one cycle");
    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");
`endif

endmodule

/* design/twiddle_gain_tuner.sv */
// Channel   Dir  Payload                                   Transfer
// i_sample  in   cross_track_error (16b signed)            valid & ready
// o_result  out  gain_p, gain_i, gain_d, average_error     valid & ready
// i_cfg_*   in   index (3b), data (32b)                    i_cfg_we
//
// One sample at a time, through the bit-serial shared divider (DW = max(ERR_WIDTH, 36));
// a step that is rescaled takes a further pass through that divider.
// The first sample after a gain register write derives the step of each written gain
// (its step, gain/10, goes through the same divider).
// Reset is synchronous, active low; no clearing pass.
// A stalled result holds in the output register; the next sample is taken meanwhile.
module twiddle_gain_tuner import twg_pkg::*; #(
    parameter int NUM_GAINS = 3,
    parameter int ERR_WIDTH = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    twg_stream_if.sink            i_sample,
    twg_stream_if.source          o_result
);
    localparam int DW = (ERR_WIDTH > 36) ? ERR_WIDTH : 36;
    localparam logic [ERR_WIDTH-1:0] ERR_MASK = '1;
    localparam logic [1:0] LAST_IDX = 2'(NUM_GAINS - 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PREP  = 9'b000000010,
        S_SDIV  = 9'b000000100,
        S_UPD   = 9'b000001000,
        S_MDIV  = 9'b000010000,
        S_DEC   = 9'b000100000,
        S_SCDIV = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state                    r_state;
    logic [30:0]               r_tol;
    logic [15:0]               r_warm;
    logic [15:0]               r_limit;
    logic signed [31:0]        r_gain [GAIN_SLOTS];
    logic signed [31:0]        r_step [GAIN_SLOTS];
    logic [GAIN_SLOTS-1:0]     r_pend;
    logic [15:0]               r_run;
    logic [ERR_WIDTH-1:0]      r_sum;
    logic [ERR_WIDTH-1:0]      r_mean;
    logic [ERR_WIDTH-1:0]      r_low;
    logic [1:0]                r_gidx;
    logic                      r_try;
    logic [30:0]               r_sq;
    logic [1:0]                r_sidx;
    logic                      r_sneg;
    logic                      r_ovalid;
    t_result                   r_out;

    logic                      dv_start;
    logic [DW-1:0]             dv_dividend;
    logic [15:0]               dv_divisor;
    t_div_stat                 dv_stat;
    logic [DW-1:0]             dv_quot;

    logic [15:0]               n_run;
    logic [ERR_WIDTH:0]        n_sumfull;
    logic [ERR_WIDTH-1:0]      n_sum;
    logic [16:0]               n_diff;
    logic [16:0]               n_negdiff;
    logic [15:0]               n_div;
    logic [1:0]                n_pidx;
    logic                      n_any_pend;
    logic signed [35:0]        n_total;
    logic                      n_act;
    logic                      n_less;
    logic [1:0]                n_next;
    logic                      n_scale;
    logic [3:0]                n_num;
    logic signed [32:0]        n_sx;
    logic [32:0]               n_mag;
    logic signed [35:0]        n_qs;
    logic signed [31:0]        n_qval;
    logic signed [31:0]        n_gi;
    logic signed [31:0]        n_si;
    logic signed [31:0]        n_gf;
    logic signed [31:0]        n_sf;
    logic signed [31:0]        n_prod;
    logic                      n_accept;

    assign n_accept = i_sample.valid && i_sample.ready;
    assign i_sample.ready = (r_state == S_IDLE);

    // Select the gain whose step still has to be derived
    always_comb begin
        n_pidx     = 2'd0;
        n_any_pend = |r_pend;
        for (int k = GAIN_SLOTS - 1; k >= 0; k--) begin
            if (r_pend[k]) begin
                n_pidx = 2'(k);
            end
        end
    end

    // Run counter, error sum and mean divisor
    always_comb begin
        n_run     = ((r_run == r_limit) ? 16'd0 : r_run) + 16'd1;
        n_sumfull = {1'b0, r_sum} + (ERR_WIDTH + 1)'(r_sq);
        if (n_run < r_warm) begin
            n_sum = '0;
        end else if (n_sumfull[ERR_WIDTH]) begin
            n_sum = ERR_MASK;
        end else begin
            n_sum = n_sumfull[ERR_WIDTH-1:0];
        end
        n_diff    = {1'b0, n_run} - {1'b0, r_warm};
        n_negdiff = 17'd0 - n_diff;
        n_div     = n_diff[16] ? n_negdiff[15:0] : n_diff[15:0];
    end

    // Twiddle decision
    always_comb begin
        n_total = '0;
        for (int k = 0; k < NUM_GAINS; k++) begin
            n_total = n_total + 36'(r_step[k]);
        end
        n_act  = (r_run > r_warm) && (n_total > $signed({5'd0, r_tol}));
        n_less = r_mean < r_low;
        n_next = (r_gidx == LAST_IDX) ? 2'd0 : r_gidx + 2'd1;
        n_gi   = r_gain[r_gidx];
        n_si   = r_step[r_gidx];
        n_gf   = r_gain[r_gidx];
        n_sf   = r_step[r_gidx];
        n_scale = r_try || n_less;
        n_num  = (r_try && !n_less) ? SCALE_DOWN : SCALE_UP;
        n_sx   = 33'(r_state == S_PREP ? r_gain[n_pidx] : n_si);
        n_mag  = n_sx[32] ? 33'd0 - n_sx : n_sx;
        n_qs   = 36'($signed({2'b00, dv_quot[33:0]}));
        n_qval = sat32(r_sneg ? 36'sd0 - n_qs : n_qs);
        n_prod = i_sample.data.cross_track_error * i_sample.data.cross_track_error;
    end

    // Divider request
    always_comb begin
        dv_start    = 1'b0;
        dv_dividend = DW'(n_mag);
        dv_divisor  = TEN;
        case (r_state)
            S_PREP: begin
                dv_start = n_any_pend;
            end
            S_UPD: begin
                dv_start    = (n_div != 16'd0);
                dv_dividend = DW'(n_sum);
                dv_divisor  = n_div;
            end
            S_DEC: begin
                dv_start    = n_act && n_scale;
                dv_dividend = DW'(n_mag) * DW'(n_num);
            end
            default: begin
                dv_start = 1'b0;
            end
        endcase
    end

    twg_sdiv #(.DW(DW), .VW(16)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (dv_start),
        .i_dividend (dv_dividend),
        .i_divisor  (dv_divisor),
        .o_stat     (dv_stat),
        .o_quotient (dv_quot)
    );

    // Sequencer and tuning state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tol     <= RST_TOLERANCE;
            r_warm    <= RST_WARMUP_RUNS;
            r_limit   <= RST_CYCLE_LIMIT;
            r_gain[0] <= RST_KP;
            r_gain[1] <= RST_KI;
            r_gain[2] <= RST_KD;
            r_step[0] <= RST_STEP_P;
            r_step[1] <= RST_STEP_I;
            r_step[2] <= RST_STEP_D;
            r_pend    <= '0;
            r_run     <= '0;
            r_sum     <= '0;
            r_mean    <= '0;
            r_low     <= '0;
            r_gidx    <= '0;
            r_try     <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            // Raise valid as a result loads, drop it after its transfer
            if (r_state == S_OUT && (!r_ovalid || o_result.ready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_result.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_sq    <= n_prod[30:0];
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (n_any_pend) begin
                        r_sidx  <= n_pidx;
                        r_sneg  <= n_sx[32];
                        r_state <= S_SDIV;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_SDIV: begin
                    if (dv_stat.done) begin
                        r_step[r_sidx] <= n_qval;
                        r_pend[r_sidx] <= 1'b0;
                        r_state        <= S_PREP;
                    end
                end
                S_UPD: begin
                    // Restart: bump every gain by its step
                    if (r_run == r_limit) begin
                        for (int k = 0; k < NUM_GAINS; k++) begin
                            r_gain[k] <= sat32(36'(r_gain[k]) + 36'(r_step[k]));
                        end
                        r_low <= '0;
                        r_try <= 1'b0;
                    end
                    r_run <= n_run;
                    r_sum <= n_sum;
                    if (n_div == 16'd0) begin
                        r_mean  <= ERR_MASK;
                        r_state <= S_DEC;
                    end else begin
                        r_state <= S_MDIV;
                    end
                end
                S_MDIV: begin
                    if (dv_stat.done) begin
                        r_mean  <= dv_quot[ERR_WIDTH-1:0];
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (r_run == r_warm) begin
                        r_low <= r_mean;
                    end
                    r_sidx <= r_gidx;
                    r_sneg <= n_sx[32];
                    if (!n_act) begin
                        r_state <= S_OUT;
                    end else if (!r_try && !n_less) begin
                        r_gain[r_gidx] <= sat32(36'(n_gi) - 36'(n_si) - 36'(n_si));
                        r_try          <= 1'b1;
                        r_state        <= S_FIN;
                    end else begin
                        if (n_less) begin
                            r_low <= r_mean;
                        end else begin
                            r_gain[r_gidx] <= sat32(36'(n_gi) + 36'(n_si));
                        end
                        r_gidx  <= n_next;
                        r_try   <= 1'b0;
                        r_state <= S_SCDIV;
                    end
                end
                S_SCDIV: begin
                    if (dv_stat.done) begin
                        r_step[r_sidx] <= n_qval;
                        r_state        <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_gain[r_gidx] <= sat32(36'(n_gf) + 36'(n_sf));
                    r_state        <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || o_result.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TOLERANCE:   r_tol   <= i_cfg_data[30:0];
                    CFG_WARMUP_RUNS: r_warm  <= i_cfg_data[15:0];
                    CFG_CYCLE_LIMIT: r_limit <= i_cfg_data[15:0];
                    CFG_INITIAL_KP: begin
                        r_gain[0] <= i_cfg_data;
                        r_pend[0] <= 1'b1;
                    end
                    CFG_INITIAL_KI: begin
                        r_gain[1] <= i_cfg_data;
                        r_pend[1] <= 1'b1;
                    end
                    CFG_INITIAL_KD: begin
                        r_gain[2] <= i_cfg_data;
                        r_pend[2] <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Load the result register as the sample completes
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_ovalid || o_result.ready)) begin
            r_out.gain_p        <= r_gain[0];
            r_out.gain_i        <= r_gain[1];
            r_out.gain_d        <= r_gain[2];
            r_out.average_error <= 48'(r_mean);
        end
    end

    assign o_result.valid = r_ovalid;
    assign o_result.data  = r_out;

`ifndef ASSERT_OFF
    a_steps_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> (r_pend == '0))
        else $error("update started with a step still pending");
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gidx <= LAST_IDX)
        else $error("gain index out of range");
    a_mean_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MDIV && dv_stat.done) |=> (r_state == S_DEC))
        else $error("mean not followed by decision");
    a_wait_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCDIV && !dv_stat.done) |-> dv_stat.busy)
        else $error("waiting on an idle divider");
`endif

endmodule
